/* hw/rtl/gca_pkg.sv */
// shared types and constants of the grouped cumulative aggregator
package gca_pkg;

    localparam int NUM_GROUPS_DEF  = 1024;
    localparam int VALUE_WIDTH_DEF = 64;

    localparam int DATA_W      = 64;
    localparam int GI_W        = 11;
    localparam int IN_TDATA_W  = 80;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_TUSER_W = 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OPERATION  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SKIP_NULLS = 1'd1;

    typedef enum logic [1:0] {
        OP_SUM  = 2'd0,
        OP_PROD = 2'd1,
        OP_MAX  = 2'd2,
        OP_MIN  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MUL_LO_LO = 2'd0,
        MUL_LO_HI = 2'd1,
        MUL_HI_LO = 2'd2,
        MUL_FINAL = 2'd3
    } t_mul_step;

    typedef struct packed {
        logic      latch;
        logic      rd_en;
        logic      calc;
        logic      mul_en;
        t_mul_step mul_step;
        logic      load_out;
        logic      clr_en;
    } t_gca_cmd;

    typedef struct packed {
        logic in_clear;
        logic missing;
        logic is_prod;
        logic clr_last;
        logic out_free;
    } t_gca_stat;

endpackage

/* hw/rtl/grouped_cumulative_aggregator.sv */
// top level of the grouped cumulative aggregator
//
// rows enter on the s_axis channel; each row is answered by one item on the m_axis
// channel carrying op(row value, group accumulator) and a valid flag (0 means null).
// a clear command (tuser bit 0) empties every group and produces no item.
// operation and null handling are set through the config write port; the user
// must write them only while idle, which the block itself does not enforce.
// a row is latched, its group entry read and the operation computed; product
// then forms three half-width partial products in turn on one shared
// multiplier before the result is loaded into the output register. the block
// takes one item at a time, through the read-compute-write of the group table.
// a clear command sweeps the table, one entry per cycle, with tready low.
// after reset the same sweep runs before the first row is taken.
// results sit in an output register: a new row is accepted while the previous
// result still waits; a stalled receiver holds the next result in the datapath
// and tready stays low until that result can move into the output register.
module grouped_cumulative_aggregator #(
    parameter int NUM_GROUPS  = gca_pkg::NUM_GROUPS_DEF,
    parameter int VALUE_WIDTH = gca_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration writes
    input  logic                               i_cfg_wr_en,
    input  logic [gca_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gca_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // row input
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [10:0] group_index, [74:11] row_value, [79:75] zero
    input  logic [gca_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // [0] command, [1] value_valid
    input  logic [gca_pkg::IN_TUSER_W-1:0]     i_s_axis_tuser,
    // result output
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [63:0] result_value
    output logic [gca_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // [0] result_valid
    output logic [gca_pkg::OUT_TUSER_W-1:0]    o_m_axis_tuser
);
    import gca_pkg::*;

    t_gca_cmd  w_cmd;
    t_gca_stat w_stat;

    gca_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (w_stat),
        .o_cmd           (w_cmd)
    );

    gca_dpath #(
        .NUM_GROUPS  (NUM_GROUPS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat)
    );

endmodule

/* hw/rtl/gca_ctrl.sv */
// sequencing controller: clearing sweep, row read, compute, product steps, result hand-off
module gca_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  gca_pkg::t_gca_stat i_stat,
    output gca_pkg::t_gca_cmd  o_cmd
);
    import gca_pkg::*;

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_READ = 9'b000000100,
        S_CALC = 9'b000001000,
        S_MUL0 = 9'b000010000,
        S_MUL1 = 9'b000100000,
        S_MUL2 = 9'b001000000,
        S_MUL3 = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = o_s_axis_tready && i_s_axis_tvalid;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.mul_step = MUL_LO_LO;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_en = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.latch = 1'b1;
                    n_state = i_stat.in_clear ? S_CLR : S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state = (i_stat.is_prod && !i_stat.missing) ? S_MUL0 : S_DONE;
            end
            S_MUL0: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_step = MUL_LO_LO;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_step = MUL_LO_HI;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_step = MUL_HI_LO;
                n_state = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_step = MUL_FINAL;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/gca_dpath.sv */
// datapath: group table memory, operation unit, shared multiplier, output register
module gca_dpath #(
    parameter int NUM_GROUPS  = gca_pkg::NUM_GROUPS_DEF,
    parameter int VALUE_WIDTH = gca_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [gca_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gca_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [gca_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    input  logic [gca_pkg::IN_TUSER_W-1:0]     i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [gca_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic [gca_pkg::OUT_TUSER_W-1:0]    o_m_axis_tuser,
    input  gca_pkg::t_gca_cmd                  i_cmd,
    output gca_pkg::t_gca_stat                 o_stat
);
    import gca_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int AW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int HW = (VW + 1) / 2;
    localparam int PW = 2 * HW;
    localparam int EW = VW + 2;

    // table entry: {poisoned, started, accumulator}
    logic [EW-1:0] mem [NUM_GROUPS];

    // configuration
    t_op  r_op;
    logic r_skip;

    // latched item
    logic [VW-1:0] r_val;
    logic          r_vvalid;
    logic          r_missing;
    logic [AW-1:0] r_addr;

    // clearing sweep
    logic [AW-1:0] r_clr_cnt;

    // compute
    logic [EW-1:0] r_rdata;
    logic [VW-1:0] r_acc;
    logic [VW-1:0] r_nv;
    logic          r_upd;
    logic          r_poison_set;
    logic [PW-1:0] r_mp;
    logic [PW-1:0] r_prod;

    // output register
    logic             r_out_valid;
    logic [VW-1:0]    r_out_value;
    logic             r_out_ok;

    logic [GI_W-1:0]  w_gi;
    logic [GI_W-2:0]  w_gidx;
    logic             w_in_range;
    logic             w_started;
    logic             w_poisoned;
    logic [VW-1:0]    w_old;
    logic [VW-1:0]    w_ident;
    logic [VW-1:0]    w_acc;
    logic [VW-1:0]    w_res;
    logic [PW-1:0]    w_val_ext;
    logic [PW-1:0]    w_acc_ext;
    logic [HW-1:0]    w_ma;
    logic [HW-1:0]    w_mb;
    logic [PW-1:0]    w_mul;
    logic [PW-1:0]    w_prod_next;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [EW-1:0]    w_wdata;

    // input unpacking
    assign w_gi       = i_s_axis_tdata[GI_W-1:0];
    assign w_gidx     = w_gi[GI_W-2:0];
    assign w_in_range = !w_gi[GI_W-1] && (32'(w_gidx) < NUM_GROUPS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op   <= OP_SUM;
            r_skip <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_IDX_OPERATION:  r_op   <= t_op'(i_cfg_data[1:0]);
                CFG_IDX_SKIP_NULLS: r_skip <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_val     <= i_s_axis_tdata[GI_W +: VW];
            r_vvalid  <= i_s_axis_tuser[1];
            r_missing <= !w_in_range;
            r_addr    <= AW'(w_gidx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_cnt <= o_stat.clr_last ? '0 : r_clr_cnt + 1'b1;
        end
    end

    // group table
    assign w_we    = i_cmd.clr_en || (i_cmd.load_out && (r_upd || r_poison_set));
    assign w_waddr = i_cmd.clr_en ? r_clr_cnt : r_addr;
    assign w_wdata = i_cmd.clr_en ? '0 :
                     {w_poisoned | r_poison_set, w_started | r_upd, r_upd ? r_nv : w_old};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= mem[r_addr];
        end
    end

    assign w_old      = r_rdata[VW-1:0];
    assign w_started  = r_rdata[VW];
    assign w_poisoned = r_rdata[VW+1];

    always_comb begin
        case (r_op)
            OP_SUM:  w_ident = '0;
            OP_PROD: w_ident = VW'(1);
            OP_MAX:  w_ident = {1'b1, {(VW-1){1'b0}}};
            OP_MIN:  w_ident = {1'b0, {(VW-1){1'b1}}};
            default: w_ident = '0;
        endcase
    end

    assign w_acc = w_started ? w_old : w_ident;

    always_comb begin
        case (r_op)
            OP_SUM:  w_res = r_val + w_acc;
            OP_MAX:  w_res = ($signed(r_val) < $signed(w_acc)) ? w_acc : r_val;
            OP_MIN:  w_res = ($signed(w_acc) < $signed(r_val)) ? w_acc : r_val;
            default: w_res = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_acc        <= w_acc;
            r_nv         <= r_missing ? '0 : w_res;
            r_upd        <= !r_missing && r_vvalid && (r_skip || !w_poisoned);
            r_poison_set <= !r_missing && !r_skip && !r_vvalid;
        end else if (i_cmd.mul_en && (i_cmd.mul_step == MUL_FINAL)) begin
            r_nv <= w_prod_next[VW-1:0];
        end
    end

    // low word of the product from three half-width partial products
    assign w_val_ext = PW'(r_val);
    assign w_acc_ext = PW'(r_acc);

    always_comb begin
        case (i_cmd.mul_step)
            MUL_LO_LO: begin
                w_ma = w_val_ext[HW-1:0];
                w_mb = w_acc_ext[HW-1:0];
            end
            MUL_LO_HI: begin
                w_ma = w_val_ext[HW-1:0];
                w_mb = w_acc_ext[PW-1:HW];
            end
            MUL_HI_LO: begin
                w_ma = w_val_ext[PW-1:HW];
                w_mb = w_acc_ext[HW-1:0];
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mul       = w_ma * w_mb;
    assign w_prod_next = r_prod + (r_mp << HW);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_mp <= w_mul;
            case (i_cmd.mul_step)
                MUL_LO_LO: r_prod <= r_prod;
                MUL_LO_HI: r_prod <= r_mp;
                default:   r_prod <= w_prod_next;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_value <= r_nv;
            r_out_ok    <= r_upd;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = OUT_TDATA_W'($signed(r_out_value));
    assign o_m_axis_tuser[0] = r_out_ok;

    assign o_stat.in_clear = i_s_axis_tuser[0];
    assign o_stat.missing  = r_missing;
    assign o_stat.is_prod  = (r_op == OP_PROD);
    assign o_stat.clr_last = (32'(r_clr_cnt) == NUM_GROUPS - 1);
    assign o_stat.out_free = !r_out_valid || i_m_axis_tready;

endmodule

/* tb/grouped_cumulative_aggregator_tb.sv */
// testbench of the grouped cumulative aggregator: streamed rows checked against a per-group scan
`timescale 1ns / 1ps

module grouped_cumulative_aggregator_tb;
    import gca_pkg::*;

    localparam int          NUM_GROUPS     = NUM_GROUPS_DEF;
    localparam int          SETTLE_CYCLES  = NUM_GROUPS + 16;
    localparam int          QUIET_LIMIT    = 20000;
    localparam int          LONG_HOLD      = 300;
    localparam int          ROWS_PER_PHASE = 54;
    localparam logic [63:0] MAX_POS        = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_NEG        = 64'h8000_0000_0000_0000;
    localparam logic [10:0] MISSING_KEY    = 11'h7FF;

    typedef struct packed {
        logic              cmd;
        logic [GI_W-1:0]   grp;
        logic [DATA_W-1:0] val;
        logic              vld;
    } t_row;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              valid;
    } t_agg_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  i_s_axis_tuser = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;

    // scan model state
    logic [DATA_W-1:0]   grp_accum [NUM_GROUPS];
    bit [NUM_GROUPS-1:0] grp_started = '0;
    bit [NUM_GROUPS-1:0] grp_poisoned = '0;
    t_op                 model_op = OP_SUM;
    bit                  model_skip = 1'b1;

    t_row        row_q [$];
    t_agg_result agg_results_q [$];
    int          errors = 0;
    int          quiet_cycles = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    int          hold_req = 0;
    int          hold_ack = 0;
    bit          no_idle = 1'b0;

    t_op phase_op [8] = '{OP_SUM, OP_PROD, OP_MAX, OP_MIN, OP_SUM, OP_PROD, OP_MAX, OP_MIN};
    bit  phase_skip [8] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    grouped_cumulative_aggregator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] op_identity(input t_op op);
        case (op)
            OP_SUM:  return '0;
            OP_PROD: return 64'd1;
            OP_MAX:  return MIN_NEG;
            default: return MAX_POS;
        endcase
    endfunction

    // advance the per-group scan by one accepted item
    function automatic void scan_row(input t_row r);
        logic [DATA_W-1:0] acc_v;
        t_agg_result       res;
        int unsigned       g;
        if (r.cmd) begin
            grp_started  = '0;
            grp_poisoned = '0;
            return;
        end
        g = r.grp;
        if (r.grp[GI_W-1] || g >= NUM_GROUPS) begin
            res.value = '0;
            res.valid = 1'b0;
            agg_results_q.insert(agg_results_q.size(), res);
            return;
        end
        acc_v = grp_started[g] ? grp_accum[g] : op_identity(model_op);
        case (model_op)
            OP_SUM:  res.value = r.val + acc_v;
            OP_PROD: res.value = r.val * acc_v;
            OP_MAX:  res.value = ($signed(r.val) < $signed(acc_v)) ? acc_v : r.val;
            default: res.value = ($signed(acc_v) < $signed(r.val)) ? acc_v : r.val;
        endcase
        res.valid = r.vld;
        if (!r.vld) begin
            if (!model_skip)
                grp_poisoned[g] = 1'b1;
        end else if (!model_skip && grp_poisoned[g]) begin
            res.valid = 1'b0;
        end else begin
            grp_accum[g]   = res.value;
            grp_started[g] = 1'b1;
        end
        agg_results_q.insert(agg_results_q.size(), res);
    endfunction

    function automatic void check_result(input logic [DATA_W-1:0] value, input logic valid);
        t_agg_result want;
        if (agg_results_q.size() == 0) begin
            $error("unexpected result: result_value %0d result_valid %0b", $signed(value), valid);
            errors++;
            return;
        end
        want = agg_results_q.pop_front();
        if (value !== want.value) begin
            $error("result_value: expected %0d, got %0d", $signed(want.value), $signed(value));
            errors++;
        end
        if (valid !== want.valid) begin
            $error("result_valid: expected %0b, got %0b", want.valid, valid);
            errors++;
        end
    endfunction

    // row driver
    always @(posedge i_clk) begin : row_driver
        t_row nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            send_gap        <= 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                scan_row({i_s_axis_tuser[0], i_s_axis_tdata[GI_W-1:0],
                          i_s_axis_tdata[GI_W +: DATA_W], i_s_axis_tuser[1]});
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (send_gap != 0) begin
                    send_gap        <= send_gap - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else if (row_q.size() != 0) begin
                    nxt = row_q.pop_front();
                    i_s_axis_tdata  <= {5'b0, nxt.val, nxt.grp};
                    i_s_axis_tuser  <= {nxt.vld, nxt.cmd};
                    i_s_axis_tvalid <= 1'b1;
                    send_gap        <= no_idle ? 0 : $urandom_range(0, 4);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(posedge i_clk) begin : result_monitor
        int stall;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_left      <= 0;
            hold_left       <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                check_result(o_m_axis_tdata, o_m_axis_tuser[0]);
            if (hold_left != 0) begin
                hold_left       <= hold_left - 1;
                i_m_axis_tready <= (hold_left == 1);
            end else if (hold_req != hold_ack) begin
                hold_ack        <= hold_req;
                hold_left       <= LONG_HOLD;
                i_m_axis_tready <= 1'b0;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                stall           = no_idle ? 0 : $urandom_range(0, 4);
                stall_left      <= stall;
                i_m_axis_tready <= (stall == 0);
            end else if (stall_left != 0) begin
                stall_left      <= stall_left - 1;
                i_m_axis_tready <= (stall_left == 1);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_IDX_OPERATION)
            model_op = t_op'(data);
        else
            model_skip = data[0];
    endtask

    task automatic set_mode(input t_op op, input bit skip);
        cfg_write(CFG_IDX_OPERATION, op);
        cfg_write(CFG_IDX_SKIP_NULLS, {1'b0, skip});
        @(negedge i_clk);
    endtask

    task automatic push_row(input logic cmd, input logic [GI_W-1:0] grp,
                            input logic [DATA_W-1:0] val, input logic vld);
        row_q.insert(row_q.size(), {cmd, grp, val, vld});
    endtask

    task automatic push_random_row(input bit skip);
        logic [GI_W-1:0]   grp;
        logic [DATA_W-1:0] val;
        int                small_v;
        int unsigned       pick;
        pick = $urandom_range(0, 19);
        // most rows hit a few groups so the scans run long
        if (pick < 14)
            grp = GI_W'($urandom_range(0, 7));
        else if (pick < 16)
            grp = GI_W'($urandom_range(0, NUM_GROUPS - 1));
        else if (pick < 18)
            grp = MISSING_KEY;
        else
            grp = {1'b1, 10'($urandom_range(0, 1022))};
        small_v = int'($urandom_range(0, 20)) - 10;
        case ($urandom_range(0, 9))
            0:       val = MIN_NEG;
            1:       val = MAX_POS;
            2, 3, 4: val = {$urandom, $urandom};
            default: val = {{32{small_v[31]}}, small_v};
        endcase
        push_row($urandom_range(0, 59) == 0, grp, val,
                 skip ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 14) != 0));
    endtask

    // all items sent and answered, then room for a clear sweep still running
    task automatic wait_idle();
        do @(negedge i_clk);
        while (row_q.size() != 0 || i_s_axis_tvalid || agg_results_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // sum with wrap, missing keys, skipped null, clear
        set_mode(OP_SUM, 1'b1);
        push_row(1'b0, 11'd0, MAX_POS, 1'b1);
        push_row(1'b0, 11'd0, 64'd1, 1'b1);
        push_row(1'b0, 11'd1023, MIN_NEG, 1'b1);
        push_row(1'b0, 11'd1023, '1, 1'b1);
        push_row(1'b0, MISSING_KEY, 64'd42, 1'b1);
        push_row(1'b0, 11'h400, MAX_POS, 1'b1);
        push_row(1'b0, 11'd0, 64'd5, 1'b0);
        push_row(1'b1, 11'h3FF, '1, 1'b1);
        push_row(1'b0, 11'd0, 64'd7, 1'b1);
        wait_idle();

        // product with wrap and poisoning
        set_mode(OP_PROD, 1'b0);
        push_row(1'b0, 11'd2, '1, 1'b1);
        push_row(1'b0, 11'd2, MAX_POS, 1'b1);
        push_row(1'b0, 11'd2, 64'd9, 1'b0);
        push_row(1'b0, 11'd2, 64'd3, 1'b1);
        push_row(1'b0, 11'd3, 64'd0, 1'b1);
        wait_idle();

        // max on a group started under sum keeps its accumulator
        set_mode(OP_MAX, 1'b1);
        push_row(1'b0, 11'd0, 64'd3, 1'b1);
        push_row(1'b0, 11'd4, MIN_NEG, 1'b1);
        push_row(1'b0, 11'd0, MAX_POS, 1'b1);
        wait_idle();

        // min, poison from an earlier phase still holds
        set_mode(OP_MIN, 1'b0);
        push_row(1'b0, 11'd0, 64'd100, 1'b1);
        push_row(1'b0, 11'd5, MAX_POS, 1'b1);
        push_row(1'b0, 11'd5, MIN_NEG, 1'b1);
        push_row(1'b0, 11'd2, 64'd1, 1'b1);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            set_mode(phase_op[p], phase_skip[p]);
            no_idle = (p == 2 || p == 5);
            if (p == 1)
                hold_req++;
            repeat (ROWS_PER_PHASE) push_random_row(phase_skip[p]);
            wait_idle();
        end

        if (errors == 0 && agg_results_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/gca_pkg.sv
hw/rtl/gca_ctrl.sv
hw/rtl/gca_dpath.sv
hw/rtl/grouped_cumulative_aggregator.sv
tb/grouped_cumulative_aggregator_tb.sv
